[sv/isotp_pkg.sv]
// Shared types and constants for the ISO-TP frame reassembler.
package isotp_pkg;

    // Frame geometry
    localparam int          SEG_BYTES     = 7;
    localparam logic [3:0]  MAX_FRAME_LEN = 4'd8;
    localparam logic [3:0]  FF_HDR_LEN    = 4'd2;
    localparam logic [3:0]  CF_HDR_LEN    = 4'd1;
    localparam logic [3:0]  SEQ_FIRST     = 4'd1;

    // Protocol control nibble codes
    localparam logic [3:0]  PCI_SF = 4'h0;
    localparam logic [3:0]  PCI_FF = 4'h1;
    localparam logic [3:0]  PCI_CF = 4'h2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Frame class decided by the front
    typedef enum logic [2:0] {
        K_ERR,
        K_SF,
        K_FF,
        K_FF_ZERO,
        K_CF
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ERROR      = 2'd0,
        ST_COMPLETE   = 2'd1,
        ST_NEED_FC    = 2'd2,
        ST_COLLECTING = 2'd3
    } t_status;

    // Classified frame as queued for the back
    typedef struct packed {
        t_kind                       kind;
        logic [3:0]                  seq;
        logic [2:0]                  cnt;
        logic [11:0]                 msg_len;
        logic [SEG_BYTES-1:0][7:0]   data;
    } t_cls_item;

    // Result as held in the output register
    typedef struct packed {
        t_status                     status;
        logic [11:0]                 seg_offset;
        logic [2:0]                  seg_count;
        logic [11:0]                 message_length;
        logic [SEG_BYTES-1:0][7:0]   seg_bytes;
    } t_seg_res;

endpackage

[sv/isotp_if.sv]
// Channel interfaces: incoming CAN frames and outgoing payload segments.
interface isotp_frame_if;
    logic       valid;
    logic       ready;
    logic [3:0] frame_len;
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic [7:0] byte_6;
    logic [7:0] byte_7;

    modport source (
        output valid, frame_len, byte_0, byte_1, byte_2, byte_3,
               byte_4, byte_5, byte_6, byte_7,
        input  ready
    );
    modport sink (
        input  valid, frame_len, byte_0, byte_1, byte_2, byte_3,
               byte_4, byte_5, byte_6, byte_7,
        output ready
    );
endinterface

interface isotp_seg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] seg_offset;
    logic [2:0]  seg_count;
    logic [11:0] message_length;
    logic [7:0]  seg_byte_0;
    logic [7:0]  seg_byte_1;
    logic [7:0]  seg_byte_2;
    logic [7:0]  seg_byte_3;
    logic [7:0]  seg_byte_4;
    logic [7:0]  seg_byte_5;
    logic [7:0]  seg_byte_6;

    modport source (
        output valid, status, seg_offset, seg_count, message_length,
               seg_byte_0, seg_byte_1, seg_byte_2, seg_byte_3,
               seg_byte_4, seg_byte_5, seg_byte_6,
        input  ready
    );
    modport sink (
        input  valid, status, seg_offset, seg_count, message_length,
               seg_byte_0, seg_byte_1, seg_byte_2, seg_byte_3,
               seg_byte_4, seg_byte_5, seg_byte_6,
        output ready
    );
endinterface

[sv/isotp_front.sv]
// Front: accepts frames and classifies them without looking at reassembly state.
module isotp_front import isotp_pkg::*; (
    isotp_frame_if.sink  i_frame,
    output logic         o_push_valid,
    output t_cls_item    o_push_item,
    input  logic         i_push_ready
);

    logic [3:0]  len_c;
    logic [3:0]  pci_type;
    logic [3:0]  pci_low;
    logic [11:0] ff_len;
    logic [3:0]  ff_take;
    logic [3:0]  cf_take;

    // Handshake passes straight to the queue
    assign i_frame.ready = i_push_ready;
    assign o_push_valid  = i_frame.valid;

    // Clamp length code, split control byte
    always_comb begin
        len_c    = (i_frame.frame_len > MAX_FRAME_LEN) ? MAX_FRAME_LEN : i_frame.frame_len;
        pci_type = i_frame.byte_0[7:4];
        pci_low  = i_frame.byte_0[3:0];
        ff_len   = {pci_low, i_frame.byte_1};
        ff_take  = len_c - FF_HDR_LEN;
        cf_take  = len_c - CF_HDR_LEN;
    end

    // Classification
    always_comb begin
        o_push_item.kind    = K_ERR;
        o_push_item.seq     = pci_low;
        o_push_item.cnt     = 3'd0;
        o_push_item.msg_len = 12'd0;
        o_push_item.data    = {i_frame.byte_7, i_frame.byte_6, i_frame.byte_5,
                               i_frame.byte_4, i_frame.byte_3, i_frame.byte_2,
                               i_frame.byte_1};
        if (len_c != 4'd0) begin
            case (pci_type)
                PCI_SF: begin
                    // payload must fit behind the control byte
                    if (pci_low != 4'd0 && pci_low < len_c) begin
                        o_push_item.kind    = K_SF;
                        o_push_item.cnt     = pci_low[2:0];
                        o_push_item.msg_len = {8'd0, pci_low};
                    end
                end
                PCI_FF: begin
                    if (len_c >= FF_HDR_LEN) begin
                        o_push_item.kind    = (ff_len == 12'd0) ? K_FF_ZERO : K_FF;
                        o_push_item.cnt     = (ff_len < {8'd0, ff_take}) ?
                                              ff_len[2:0] : ff_take[2:0];
                        o_push_item.msg_len = ff_len;
                        o_push_item.data    = {8'h00, i_frame.byte_7, i_frame.byte_6,
                                               i_frame.byte_5, i_frame.byte_4,
                                               i_frame.byte_3, i_frame.byte_2};
                    end
                end
                PCI_CF: begin
                    o_push_item.kind = K_CF;
                    o_push_item.cnt  = cf_take[2:0];
                end
                default: begin
                    o_push_item.kind = K_ERR;
                end
            endcase
        end
    end

endmodule

[sv/isotp_queue.sv]
// Short register queue of classified frames between front and back.
module isotp_queue import isotp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push_valid,
    input  t_cls_item  i_push_item,
    output logic       o_push_ready,
    output logic       o_pop_valid,
    output t_cls_item  o_pop_item,
    input  logic       i_pop_ready
);

    t_cls_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [QUEUE_CNT_W-1:0]  r_count;
    logic                    push;
    logic                    pop;

    assign o_push_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + QUEUE_CNT_W'(1);
                2'b01:   r_count <= r_count - QUEUE_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[sv/isotp_back.sv]
// Back: reassembly state, sequence checks and the registered result.
module isotp_back import isotp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop_valid,
    input  t_cls_item     i_pop_item,
    output logic          o_pop_ready,
    isotp_seg_if.source   o_seg
);

    logic [11:0] r_exp_len;
    logic [11:0] r_rcv_cnt;
    logic [3:0]  r_next_seq;
    logic        r_collecting;
    logic        r_out_valid;
    t_seg_res    r_res;

    logic [11:0] n_exp_len;
    logic [11:0] n_rcv_cnt;
    logic [3:0]  n_next_seq;
    logic        n_collecting;
    t_seg_res    n_res;

    logic        load;
    logic [11:0] remaining;
    logic [2:0]  cf_take;
    logic [11:0] cf_rcv;

    // Output register frees when empty or being taken
    assign o_pop_ready = !r_out_valid || o_seg.ready;
    assign load        = i_pop_valid && o_pop_ready;

    // Consecutive frame arithmetic
    always_comb begin
        remaining = (r_exp_len > r_rcv_cnt) ? (r_exp_len - r_rcv_cnt) : 12'd0;
        cf_take   = (remaining < {9'd0, i_pop_item.cnt}) ? remaining[2:0] : i_pop_item.cnt;
        cf_rcv    = r_rcv_cnt + {9'd0, cf_take};
    end

    // Next state and result
    always_comb begin
        n_exp_len            = r_exp_len;
        n_rcv_cnt            = r_rcv_cnt;
        n_next_seq           = r_next_seq;
        n_collecting         = r_collecting;
        n_res.status         = ST_ERROR;
        n_res.seg_offset     = 12'd0;
        n_res.seg_count      = 3'd0;
        n_res.message_length = 12'd0;
        n_res.seg_bytes      = '0;
        case (i_pop_item.kind)
            K_SF: begin
                n_exp_len            = 12'd0;
                n_rcv_cnt            = {9'd0, i_pop_item.cnt};
                n_next_seq           = 4'd0;
                n_collecting         = 1'b0;
                n_res.status         = ST_COMPLETE;
                n_res.seg_count      = i_pop_item.cnt;
                n_res.message_length = i_pop_item.msg_len;
            end
            K_FF: begin
                n_exp_len            = i_pop_item.msg_len;
                n_rcv_cnt            = {9'd0, i_pop_item.cnt};
                n_next_seq           = SEQ_FIRST;
                n_collecting         = 1'b1;
                n_res.status         = ST_NEED_FC;
                n_res.seg_count      = i_pop_item.cnt;
                n_res.message_length = i_pop_item.msg_len;
            end
            K_FF_ZERO: begin
                // zero-length first frame drops any message in progress
                n_exp_len    = 12'd0;
                n_rcv_cnt    = 12'd0;
                n_next_seq   = 4'd0;
                n_collecting = 1'b0;
            end
            K_CF: begin
                if (r_collecting && i_pop_item.seq == r_next_seq) begin
                    n_next_seq           = r_next_seq + 4'd1;
                    n_rcv_cnt            = cf_rcv;
                    n_res.seg_offset     = r_rcv_cnt;
                    n_res.seg_count      = cf_take;
                    n_res.message_length = r_exp_len;
                    if (cf_rcv >= r_exp_len) begin
                        n_collecting = 1'b0;
                        n_res.status = ST_COMPLETE;
                    end else begin
                        n_res.status = ST_COLLECTING;
                    end
                end
            end
            default: begin
                n_res.status = ST_ERROR;
            end
        endcase
        // zero the bytes past the segment count
        for (int i = 0; i < SEG_BYTES; i++) begin
            if (3'(i) < n_res.seg_count) begin
                n_res.seg_bytes[i] = i_pop_item.data[i];
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len    <= 12'd0;
            r_rcv_cnt    <= 12'd0;
            r_next_seq   <= 4'd0;
            r_collecting <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (load) begin
                r_exp_len    <= n_exp_len;
                r_rcv_cnt    <= n_rcv_cnt;
                r_next_seq   <= n_next_seq;
                r_collecting <= n_collecting;
                r_out_valid  <= 1'b1;
            end else if (o_seg.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    assign o_seg.valid          = r_out_valid;
    assign o_seg.status         = r_res.status;
    assign o_seg.seg_offset     = r_res.seg_offset;
    assign o_seg.seg_count      = r_res.seg_count;
    assign o_seg.message_length = r_res.message_length;
    assign o_seg.seg_byte_0     = r_res.seg_bytes[0];
    assign o_seg.seg_byte_1     = r_res.seg_bytes[1];
    assign o_seg.seg_byte_2     = r_res.seg_bytes[2];
    assign o_seg.seg_byte_3     = r_res.seg_bytes[3];
    assign o_seg.seg_byte_4     = r_res.seg_bytes[4];
    assign o_seg.seg_byte_5     = r_res.seg_bytes[5];
    assign o_seg.seg_byte_6     = r_res.seg_bytes[6];

`ifndef NO_ASSERTIONS
    // A message in progress always has a nonzero announced length
    a_collect_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collecting |-> (r_exp_len != 12'd0))
        else $error("collecting with zero expected length");

    // Received count never passes the announced length mid-message
    a_collect_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collecting |-> (r_rcv_cnt <= r_exp_len))
        else $error("received count beyond expected length");

    // A delivered segment stays inside its message
    a_seg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.status != ST_ERROR)) |->
        (({1'b0, r_res.seg_offset} + {10'd0, r_res.seg_count}) <=
         {1'b0, r_res.message_length}))
        else $error("segment runs past message length");

    // Error results carry an empty segment
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.status == ST_ERROR)) |->
        ((r_res.seg_count == 3'd0) && (r_res.message_length == 12'd0)))
        else $error("error result with payload");

    // Completing a consecutive frame ends collection
    a_cf_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (i_pop_item.kind == K_CF) && (n_res.status == ST_COMPLETE)) |=>
        !r_collecting)
        else $error("still collecting after completion");
`endif

endmodule

[sv/isotp_frame_reassembler.sv]
// ISO-TP receive reassembler top level: front classifier, queue, state back end.
// Takes one CAN frame per clock while the queue has room and gives one result
// per frame: a status and the payload segment (offset, count, up to seven
// bytes) the frame adds to the message; the message itself is not stored, so
// the receiver places each segment at its offset. Sustained rate is one frame
// per cycle while the output stays ready; the limit is the back end's update of
// length, count and sequence number. From frame accept to result valid, a
// frame passes through the classifier into the two-entry queue, then through
// the result register. Input ready stays high while the queue has room, so a
// stalled output only back-pressures the input once both queue entries and
// the result register are occupied.
module isotp_frame_reassembler import isotp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    isotp_frame_if.sink   i_frame,
    isotp_seg_if.source   o_seg
);

    logic       push_valid;
    logic       push_ready;
    t_cls_item  push_item;
    logic       pop_valid;
    logic       pop_ready;
    t_cls_item  pop_item;

    // Frame classification
    isotp_front u_front (
        .i_frame      (i_frame),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    // Decoupling queue
    isotp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    // Reassembly state and result register
    isotp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_item  (pop_item),
        .o_pop_ready (pop_ready),
        .o_seg       (o_seg)
    );

endmodule
